[hdl/evm_pkg.sv]
// Shared constants and helpers for the Euler Y-X-Z view matrix block.
`timescale 1ns / 1ps
package evm_pkg;

	localparam int CORDIC_FRAC = 30;
	localparam int ATAN_COUNT = 24;
	localparam int Q16_W = 20;
	localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	// arctangent of 2^-i in units of 2^-32 turn
	localparam logic [31:0] ATAN_TURNS [ATAN_COUNT] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// angles in the left half plane are turned by a half turn
	function automatic logic angle_flip(input logic [15:0] a);
		angle_flip = (a >= 16'd16384) && (a < 16'd49152);
	endfunction

	function automatic logic signed [32:0] angle_start(input logic [15:0] a);
		logic [15:0] r;
		r = angle_flip(a) ? a + 16'd32768 : a;
		angle_start = 33'($signed({r, 16'h0000}));
	endfunction

endpackage

[hdl/evm_front.sv]
// Front end: input acceptance and pipelined three-lane CORDIC sine/cosine.
`timescale 1ns / 1ps
module evm_front
	import evm_pkg::*;
#(
	parameter int CORDIC_STAGES = 16,
	parameter int FRAC_BITS = 16,
	parameter int W = FRAC_BITS + 3,
	parameter int EW = 6 * W + 96
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [143:0]  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [EW-1:0] out_data
);

	localparam int N = CORDIC_STAGES;
	localparam int XW = 33;
	localparam int SH = CORDIC_FRAC - FRAC_BITS;
	localparam logic signed [XW-1:0] HALF = XW'(1) <<< (SH - 1);

	logic signed [XW-1:0] x_s [0:N][0:2];
	logic signed [XW-1:0] y_s [0:N][0:2];
	logic signed [XW-1:0] z_s [0:N][0:2];
	logic                 flip_s [0:N][0:2];
	logic [95:0]          pos_s [0:N];
	logic                 vld_s [0:N];
	logic                 en;

	// the whole pipe moves unless its last stage is blocked by a full queue
	assign en = !vld_s[N] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_s[N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			pos_s[0] <= in_data[95:0];
			for (int l = 0; l < 3; l++) begin
				x_s[0][l] <= XW'($signed(CORDIC_GAIN));
				y_s[0][l] <= '0;
				z_s[0][l] <= angle_start(in_data[96 + 16*l +: 16]);
				flip_s[0][l] <= angle_flip(in_data[96 + 16*l +: 16]);
			end
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_stage
		localparam int I = k - 1;
		localparam logic signed [XW-1:0] ATN = XW'(ATAN_TURNS[I]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pos_s[k] <= pos_s[k-1];
				for (int l = 0; l < 3; l++) begin
					flip_s[k][l] <= flip_s[k-1][l];
					if (!z_s[k-1][l][XW-1]) begin
						x_s[k][l] <= x_s[k-1][l] - (y_s[k-1][l] >>> I);
						y_s[k][l] <= y_s[k-1][l] + (x_s[k-1][l] >>> I);
						z_s[k][l] <= z_s[k-1][l] - ATN;
					end else begin
						x_s[k][l] <= x_s[k-1][l] + (y_s[k-1][l] >>> I);
						y_s[k][l] <= y_s[k-1][l] - (x_s[k-1][l] >>> I);
						z_s[k][l] <= z_s[k-1][l] + ATN;
					end
				end
			end
		end
	end

	// round to FRAC_BITS and undo the half-turn fold
	always_comb begin
		logic signed [XW-1:0] xr;
		logic signed [XW-1:0] yr;
		logic signed [W-1:0]  cv;
		logic signed [W-1:0]  sv;
		out_data = '0;
		out_data[6*W +: 96] = pos_s[N];
		for (int l = 0; l < 3; l++) begin
			xr = (x_s[N][l] + HALF) >>> SH;
			yr = (y_s[N][l] + HALF) >>> SH;
			cv = W'(xr);
			sv = W'(yr);
			if (flip_s[N][l]) begin
				cv = -cv;
				sv = -sv;
			end
			out_data[2*W*l +: W] = sv;
			out_data[2*W*l + W +: W] = cv;
		end
	end

endmodule

[hdl/evm_queue.sv]
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps
module evm_queue #(
	parameter int EW = 210
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [EW-1:0] in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [EW-1:0] out_data
);

	localparam int DEPTH = 2;
	localparam int AW = $clog2(DEPTH);

	logic [EW-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;
	logic          push;
	logic          pop;

	assign in_ready = cnt_q != (AW+1)'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_data;
	end

endmodule

[hdl/evm_back.sv]
// Back end: basis and translation arithmetic, then eight-column sequencing.
`timescale 1ns / 1ps
module evm_back
	import evm_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int W = FRAC_BITS + 3,
	parameter int EW = 6 * W + 96
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [EW-1:0] in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [127:0]  out_data,
	output logic [2:0]    out_user,
	output logic          out_last
);

	localparam int QW = Q16_W;
	localparam int PW = QW + 32;
	localparam int SHR = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

	function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [2*W-1:0] p;
		p = a * b;
		fmul = W'(p >>> FRAC_BITS);
	endfunction

	function automatic logic signed [QW-1:0] to_q16(input logic signed [W-1:0] a);
		logic signed [31:0] e;
		e = 32'(a);
		to_q16 = QW'((e <<< SHL) >>> SHR);
	endfunction

	logic signed [W-1:0] s1, c1, s2, c2, s3, c3;
	assign s2 = in_data[0 +: W];
	assign c2 = in_data[W +: W];
	assign s1 = in_data[2*W +: W];
	assign c1 = in_data[3*W +: W];
	assign s3 = in_data[4*W +: W];
	assign c3 = in_data[5*W +: W];

	logic adv;
	logic load;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	assign adv = !vld_s4 || load;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// first-level products
	logic signed [W-1:0] m0_s1, m1_s1, m3_s1, m4_s1, m6_s1, m8_s1;
	logic signed [W-1:0] m9_s1, m11_s1, m12_s1, m13_s1, s2_s1, s3_s1;
	logic [95:0] pos_s1, pos_s2, pos_s3, pos_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			m0_s1 <= fmul(c1, c3);
			m1_s1 <= fmul(s1, s2);
			m3_s1 <= fmul(c2, s3);
			m4_s1 <= fmul(c1, s2);
			m6_s1 <= fmul(c3, s1);
			m8_s1 <= fmul(c1, s3);
			m9_s1 <= fmul(c2, c3);
			m11_s1 <= fmul(s1, s3);
			m12_s1 <= fmul(c2, s1);
			m13_s1 <= fmul(c1, c2);
			s2_s1 <= s2;
			s3_s1 <= s3;
			pos_s1 <= in_data[6*W +: 96];
		end
	end

	// basis rows u, v, w in signed Q4.16 (20 bits), order u0 u1 u2 v0 v1 v2 w0 w1 w2
	logic signed [QW-1:0] b_s2 [9];
	logic signed [QW-1:0] b_s3 [9];
	logic signed [QW-1:0] b_s4 [9];

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s2[0] <= to_q16(m0_s1 + fmul(m1_s1, s3_s1));
			b_s2[1] <= to_q16(m3_s1);
			b_s2[2] <= to_q16(fmul(m4_s1, s3_s1) - m6_s1);
			b_s2[3] <= to_q16(fmul(m6_s1, s2_s1) - m8_s1);
			b_s2[4] <= to_q16(m9_s1);
			b_s2[5] <= to_q16(fmul(m0_s1, s2_s1) + m11_s1);
			b_s2[6] <= to_q16(m12_s1);
			b_s2[7] <= to_q16(-s2_s1);
			b_s2[8] <= to_q16(m13_s1);
			pos_s2 <= pos_s1;
		end
	end

	// basis times position, one product per basis entry
	logic signed [PW-1:0] pr_s3 [9];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					pr_s3[3*r+c] <= PW'(b_s2[3*r+c] * $signed(pos_s2[32*c +: 32]));
				end
			end
			b_s3 <= b_s2;
			pos_s3 <= pos_s2;
		end
	end

	// translation: negate the floored dot product, then saturate
	logic signed [31:0] t_s4 [3];

	always_ff @(posedge clk) begin
		logic signed [PW+1:0] sum;
		logic signed [PW+1:0] neg;
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				sum = (PW+2)'(pr_s3[3*r]) + (PW+2)'(pr_s3[3*r+1]) + (PW+2)'(pr_s3[3*r+2]);
				neg = -(sum >>> 16);
				if (neg > (PW+2)'(64'sh7FFF_FFFF)) t_s4[r] <= 32'sh7FFF_FFFF;
				else if (neg < -(PW+2)'(64'sh8000_0000)) t_s4[r] <= 32'sh8000_0000;
				else t_s4[r] <= 32'(neg);
			end
			b_s4 <= b_s3;
			pos_s4 <= pos_s3;
		end
	end

	// column sequencer
	logic signed [QW-1:0] b_q [9];
	logic signed [31:0]   t_q [3];
	logic [95:0]          pos_q;
	logic [2:0]           cnt_q;
	logic                 busy_q;

	assign load = vld_s4 && (!busy_q || (out_ready && cnt_q == 3'd7));
	assign out_valid = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q && out_ready) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 3'd7) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			b_q <= b_s4;
			t_q <= t_s4;
			pos_q <= pos_s4;
		end
	end

	always_comb begin
		out_user = {cnt_q[1:0], cnt_q[2]};
		out_last = cnt_q == 3'd7;
		out_data = '0;
		case (cnt_q)
			3'd0, 3'd1, 3'd2: begin
				for (int r = 0; r < 3; r++) out_data[32*r +: 32] = 32'(b_q[3*r + int'(cnt_q)]);
			end
			3'd3: begin
				for (int r = 0; r < 3; r++) out_data[32*r +: 32] = t_q[r];
				out_data[96 +: 32] = ONE_Q16;
			end
			3'd4, 3'd5, 3'd6: begin
				for (int r = 0; r < 3; r++)
					out_data[32*r +: 32] = 32'(b_q[3*(int'(cnt_q) - 4) + r]);
			end
			3'd7: begin
				out_data[95:0] = pos_q;
				out_data[96 +: 32] = ONE_Q16;
			end
			default: out_data = '0;
		endcase
	end

endmodule

[hdl/euler_yxz_view_matrix.sv]
// Top level: Euler Y-X-Z camera view and inverse view matrix generator.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  position xyz, angles xyz
// m_*      out  m_tvalid/m_tready  one matrix column per transaction, tlast on final column
//
// One input yields eight output transactions; sustained input rate is set by the single output
// channel, which sends one column per cycle while m_tready is high.
// An input passes the CORDIC pipe, the queue and 4 math stages before its first column.
// Reset clears only control state; no clearing pass.
// A stalled output backs up through the two-entry queue into the CORDIC pipe, then s_tready.
`timescale 1ns / 1ps
module euler_yxz_view_matrix
	import evm_pkg::*;
#(
	parameter int CORDIC_STAGES = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,  // pos_x, pos_y, pos_z, angle_x, angle_y, angle_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // entry_row0, entry_row1, entry_row2, entry_row3
	output logic [2:0]   m_tuser,  // matrix_select, column_index
	output logic         m_tlast
);

	localparam int W = FRAC_BITS + 3;
	localparam int EW = 6 * W + 96;

	logic          f_valid, f_ready;
	logic [EW-1:0] f_data;
	logic          q_valid, q_ready;
	logic [EW-1:0] q_data;

	evm_front #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS), .W(W), .EW(EW)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
		.out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
	);

	evm_queue #(.EW(EW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
	);

	evm_back #(.FRAC_BITS(FRAC_BITS), .W(W), .EW(EW)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata),
		.out_user(m_tuser), .out_last(m_tlast)
	);

`ifndef SYNTH
	// final column is always the inverse matrix translation column
	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == 3'b111)
		else $error("tlast on a column other than inverse column 3");

	// a run of eight columns is sent without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("column run broken");

	// columns advance in order
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
		{m_tuser[0], m_tuser[2:1]} == $past({m_tuser[0], m_tuser[2:1]}) + 3'd1)
		else $error("column out of order");
`endif

endmodule

[verif/tb_euler_yxz_view_matrix.sv]
// Self-checking testbench for the Euler Y-X-Z view matrix block.
`timescale 1ns / 1ps
module tb_euler_yxz_view_matrix;
	import evm_pkg::*;

	localparam int STAGES = 16;
	localparam int FRAC = 16;
	localparam int RANDOM_ITEMS = 330;

	typedef struct packed {
		logic        sel;
		logic [1:0]  col;
		logic [31:0] r0, r1, r2, r3;
		logic        last;
	} column_t;

	typedef struct {
		logic [31:0] px, py, pz;
		logic [15:0] ax, ay, az;
		logic        has_col;  // set where the predicted inverse column 3 row 0 must equal px
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [143:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;

	column_t columns_due[$];
	int errors = 0;
	int items_sent = 0;
	int columns_seen = 0;
	bit calm = 1'b0;

	euler_yxz_view_matrix #(.CORDIC_STAGES(STAGES), .FRAC_BITS(FRAC)) dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint floor_shift(longint x, int n);
		return x >>> n;
	endfunction

	// CORDIC sine/cosine at FRAC fraction bits
	task automatic sincos(input logic [15:0] raw, output longint s, output longint c);
		logic [15:0] a;
		bit flip;
		longint x, y, z, dx, dy, half;
		int sh;
		a = raw;
		flip = (a >= 16'd16384) && (a < 16'd49152);
		if (flip) a = a + 16'd32768;
		z = longint'($signed(a)) * 65536;
		x = longint'(CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < STAGES && i < ATAN_COUNT; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
			end
		end
		sh = CORDIC_FRAC - FRAC;
		half = longint'(1) << (sh - 1);
		x = floor_shift(x + half, sh);
		y = floor_shift(y + half, sh);
		if (flip) begin
			x = -x; y = -y;
		end
		s = y;
		c = x;
	endtask

	function automatic longint fmul(longint a, longint b);
		return floor_shift(a * b, FRAC);
	endfunction

	function automatic longint to_q16(longint v);
		if (FRAC >= 16) return floor_shift(v, FRAC - 16);
		return v * (longint'(1) << (16 - FRAC));
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	task automatic predict_columns(input row_t r);
		longint p[3], u[3], v[3], w[3];
		longint s1, c1, s2, c2, s3, c3;
		logic [31:0] t[3];
		p[0] = longint'($signed(r.px));
		p[1] = longint'($signed(r.py));
		p[2] = longint'($signed(r.pz));
		sincos(r.ax, s2, c2);
		sincos(r.ay, s1, c1);
		sincos(r.az, s3, c3);
		u[0] = fmul(c1, c3) + fmul(fmul(s1, s2), s3);
		u[1] = fmul(c2, s3);
		u[2] = fmul(fmul(c1, s2), s3) - fmul(c3, s1);
		v[0] = fmul(fmul(c3, s1), s2) - fmul(c1, s3);
		v[1] = fmul(c2, c3);
		v[2] = fmul(fmul(c1, c3), s2) + fmul(s1, s3);
		w[0] = fmul(c2, s1);
		w[1] = -s2;
		w[2] = fmul(c1, c2);
		for (int i = 0; i < 3; i++) begin
			u[i] = to_q16(u[i]); v[i] = to_q16(v[i]); w[i] = to_q16(w[i]);
		end
		t[0] = clamp32(-floor_shift(u[0] * p[0] + u[1] * p[1] + u[2] * p[2], 16));
		t[1] = clamp32(-floor_shift(v[0] * p[0] + v[1] * p[1] + v[2] * p[2], 16));
		t[2] = clamp32(-floor_shift(w[0] * p[0] + w[1] * p[1] + w[2] * p[2], 16));
		for (int i = 0; i < 3; i++)
			columns_due.push_back('{1'b0, 2'(i), u[i][31:0], v[i][31:0], w[i][31:0], 32'd0, 1'b0});
		columns_due.push_back('{1'b0, 2'd3, t[0], t[1], t[2], ONE_Q16, 1'b0});
		columns_due.push_back('{1'b1, 2'd0, u[0][31:0], u[1][31:0], u[2][31:0], 32'd0, 1'b0});
		columns_due.push_back('{1'b1, 2'd1, v[0][31:0], v[1][31:0], v[2][31:0], 32'd0, 1'b0});
		columns_due.push_back('{1'b1, 2'd2, w[0][31:0], w[1][31:0], w[2][31:0], 32'd0, 1'b0});
		columns_due.push_back('{1'b1, 2'd3, r.px, r.py, r.pz, ONE_Q16, 1'b1});
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("MISMATCH column %0d %s: got %h want %h", columns_seen, what, got, want);
	endtask

	// drop tvalid only for an idle burst; back-to-back items keep it high
	task automatic send_view(input row_t r);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		s_tdata <= {r.az, r.ay, r.ax, r.pz, r.py, r.px};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_columns(r);
		items_sent++;
		@(negedge clk);
	endtask

	// output side: random stall bursts, compare each column transaction
	initial begin
		column_t want;
		column_t got;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = '{m_tuser[0], m_tuser[2:1], m_tdata[31:0], m_tdata[63:32],
					m_tdata[95:64], m_tdata[127:96], m_tlast};
				if (columns_due.size() == 0) begin
					report_mismatch("unexpected column", 32'(got.col), '0);
				end else begin
					want = columns_due.pop_front();
					if (got.sel !== want.sel)
						report_mismatch("matrix_select", 32'(got.sel), 32'(want.sel));
					if (got.col !== want.col)
						report_mismatch("column_index", 32'(got.col), 32'(want.col));
					if (got.r0 !== want.r0) report_mismatch("entry_row0", got.r0, want.r0);
					if (got.r1 !== want.r1) report_mismatch("entry_row1", got.r1, want.r1);
					if (got.r2 !== want.r2) report_mismatch("entry_row2", got.r2, want.r2);
					if (got.r3 !== want.r3) report_mismatch("entry_row3", got.r3, want.r3);
					if (got.last !== want.last)
						report_mismatch("last_column", 32'(got.last), 32'(want.last));
				end
				columns_seen++;
			end
		end
	end

	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

	initial begin
		row_t table_rows[$];
		row_t r;
		int pick;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// extremes of positions, quarter/half-turn boundaries, saturation
		table_rows = '{
			'{32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b1},
			'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0, 16'h0, 16'h0, 1'b1},
			'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0, 16'h0, 16'h0, 1'b1},
			'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h2000, 16'h2000, 16'h2000, 1'b1},
			'{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h8000, 16'h8000, 16'h8000, 1'b0},
			'{32'h0, 32'h0, 32'h0, 16'h4000, 16'h3FFF, 16'hBFFF, 1'b0},
			'{32'h0, 32'h0, 32'h0, 16'hC000, 16'hBFFF, 16'h4000, 1'b0},
			'{32'h0010_0000, 32'hFFF0_0000, 32'h0, 16'h7FFF, 16'h8001, 16'hFFFF, 1'b0},
			'{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 16'h1234, 16'h5678, 16'h9ABC, 1'b0},
			'{32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 16'hAAAA, 16'h5555, 16'h0001, 1'b0},
			'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h6000, 16'hE000, 16'hA000, 1'b0}
		};
		foreach (table_rows[i]) begin
			send_view(table_rows[i]);
			if (table_rows[i].has_col && columns_due[$].r0 !== table_rows[i].px)
				report_mismatch("table inverse translation", columns_due[$].r0, table_rows[i].px);
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n > RANDOM_ITEMS - 40) calm = 1'b1;
			r.has_col = 1'b0;
			r.px = $urandom; r.py = $urandom; r.pz = $urandom;
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				r.px = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
				r.py = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			end else if (pick < 4) begin
				r.px = 32'($signed(16'($urandom))); r.py = 32'($signed(16'($urandom)));
				r.pz = 32'($signed(16'($urandom)));
			end
			r.ax = 16'($urandom); r.ay = 16'($urandom); r.az = 16'($urandom);
			if (pick == 1) begin
				r.ax = 16'(32'h4000 * $urandom_range(0, 3) + $urandom_range(0, 2) - 32'd1);
				r.az = 16'(32'h4000 * $urandom_range(0, 3));
			end
			send_view(r);
		end
		s_tvalid <= 1'b0;
		while (columns_due.size() != 0) @(posedge clk);
		repeat (STAGES + 20) @(posedge clk);
		$display("Sent %0d camera items, checked %0d matrix columns with stalls and gaps on both sides.",
			items_sent, columns_seen);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

[files.f]
hdl/evm_pkg.sv
hdl/evm_front.sv
hdl/evm_queue.sv
hdl/evm_back.sv
hdl/euler_yxz_view_matrix.sv
verif/tb_euler_yxz_view_matrix.sv
